// File: sv/pva_pkg.sv
package pva_pkg;

    localparam int COORD_W   = 16;
    localparam int SIDE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * SIDE_W;
    localparam int SUM_W     = 47;
    localparam int COUNT_W   = 13;
    localparam int AREA_W    = 48;
    localparam int SQ_W      = 2 * AREA_W;
    localparam int REM_W     = AREA_W + 2;
    localparam int MAG_HI_W  = SUM_W - 24;
    localparam int MAG_LO_W  = 24;
    localparam int MUL_W     = 2 * MAG_LO_W;
    localparam int STEP_W    = 6;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    // Vertex bound per polygon; the sum width holds for bounds up to 4096.
    localparam int MAX_VERTICES = 4096;

    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(9);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(AREA_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_MAG,
        ST_SQ,
        ST_ROOT,
        ST_EMIT
    } pva_state_t;

    // Partial products of one squared magnitude: hi*hi, hi*lo, lo*lo.
    typedef enum logic [1:0] {
        PART_HH,
        PART_HL,
        PART_LL
    } pva_part_t;

    typedef struct packed {
        logic [1:0] comp;
        pva_part_t  part;
    } pva_sq_sel_t;

    typedef struct packed {
        logic              take;
        logic              mul;
        logic              acc;
        logic              mag;
        logic              sq;
        logic              root;
        logic              emit;
        logic [STEP_W-1:0] step;
    } pva_cmd_t;

    function automatic pva_sq_sel_t sq_sel(input logic [STEP_W-1:0] step);
        pva_sq_sel_t s;
        unique case (step)
            STEP_W'(0): s = '{comp: 2'd0, part: PART_HH};
            STEP_W'(1): s = '{comp: 2'd0, part: PART_HL};
            STEP_W'(2): s = '{comp: 2'd0, part: PART_LL};
            STEP_W'(3): s = '{comp: 2'd1, part: PART_HH};
            STEP_W'(4): s = '{comp: 2'd1, part: PART_HL};
            STEP_W'(5): s = '{comp: 2'd1, part: PART_LL};
            STEP_W'(6): s = '{comp: 2'd2, part: PART_HH};
            STEP_W'(7): s = '{comp: 2'd2, part: PART_HL};
            STEP_W'(8): s = '{comp: 2'd2, part: PART_LL};
            default:    s = '{comp: 2'd0, part: PART_LL};
        endcase
        return s;
    endfunction

endpackage

// File: sv/pva_ctrl.sv
module pva_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pva_pkg::pva_cmd_t cmd
);

    pva_pkg::pva_state_t               state_reg, state_next;
    logic [pva_pkg::STEP_W-1:0]        step_reg, step_next;
    logic                              last_reg, last_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pva_pkg::ST_IDLE;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        last_next  = last_reg;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = pva_pkg::ST_MUL;
                    last_next  = s_tlast;
                end
            end
            pva_pkg::ST_MUL:
            begin
                state_next = pva_pkg::ST_ACC;
            end
            pva_pkg::ST_ACC:
            begin
                state_next = last_reg ? pva_pkg::ST_MAG : pva_pkg::ST_IDLE;
            end
            pva_pkg::ST_MAG:
            begin
                state_next = pva_pkg::ST_SQ;
            end
            pva_pkg::ST_SQ:
            begin
                if (step_reg == pva_pkg::SQ_LAST)
                    state_next = pva_pkg::ST_ROOT;
                else
                    step_next = step_reg + 1'b1;
            end
            pva_pkg::ST_ROOT:
            begin
                if (step_reg == pva_pkg::ROOT_LAST)
                    state_next = pva_pkg::ST_EMIT;
                else
                    step_next = step_reg + 1'b1;
            end
            pva_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = pva_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.step = step_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            pva_pkg::ST_MUL:  cmd.mul  = 1'b1;
            pva_pkg::ST_ACC:  cmd.acc  = 1'b1;
            pva_pkg::ST_MAG:  cmd.mag  = 1'b1;
            pva_pkg::ST_SQ:   cmd.sq   = 1'b1;
            pva_pkg::ST_ROOT: cmd.root = 1'b1;
            pva_pkg::ST_EMIT: cmd.emit = out_free;
            default:          cmd      = '0;
        endcase
    end

    // Hold the result until taken; a new one loads only into a free slot.
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

// File: sv/pva_datapath.sv
module pva_datapath
#(
    parameter int MAX_VERTICES = pva_pkg::MAX_VERTICES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pva_pkg::pva_cmd_t                   cmd,
    input  logic signed [pva_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [pva_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [pva_pkg::COORD_W-1:0]  coord_z,
    output logic [pva_pkg::AREA_W-1:0]          double_area,
    output logic [pva_pkg::COUNT_W-1:0]         vertex_total,
    output logic                                overflowed
);

    localparam int CW = pva_pkg::COORD_W;
    localparam int SW = pva_pkg::SIDE_W;
    localparam int PW = pva_pkg::PROD_W;
    localparam int AW = pva_pkg::SUM_W;
    localparam int QW = pva_pkg::SQ_W;
    localparam int RW = pva_pkg::REM_W;

    logic signed [CW-1:0] anchor_reg [3];
    logic signed [SW-1:0] side_reg   [3];
    logic signed [SW-1:0] prev_reg   [3];
    logic signed [PW-1:0] pa_reg     [3];
    logic signed [PW-1:0] pb_reg     [3];
    logic signed [AW-1:0] sum_reg    [3];
    logic [AW-1:0]        mag_reg    [3];
    logic [pva_pkg::COUNT_W-1:0] count_reg;
    logic                 flag_reg;
    logic                 sum_en_reg;
    logic                 prev_en_reg;

    logic [pva_pkg::MUL_W-1:0] sq_prod_reg;
    pva_pkg::pva_part_t        sq_part_reg;
    logic [QW-1:0]             sq_acc_reg;
    logic [RW-1:0]             rem_reg;
    logic [pva_pkg::AREA_W-1:0] root_reg;

    logic [pva_pkg::AREA_W-1:0]  area_reg;
    logic [pva_pkg::COUNT_W-1:0] total_reg;
    logic                        ovf_reg;

    logic signed [CW-1:0] vin [3];
    logic                 counted;

    pva_pkg::pva_sq_sel_t        sel;
    logic [AW-1:0]               mag_sel;
    logic [pva_pkg::MAG_LO_W-1:0] op_a, op_b;
    logic [QW-1:0]               sq_add;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    assign vin[0] = coord_x;
    assign vin[1] = coord_y;
    assign vin[2] = coord_z;
    assign counted = count_reg < pva_pkg::COUNT_W'(MAX_VERTICES);

    // Squaring operands: one 24x24 partial product per step.
    always_comb
    begin
        sel     = pva_pkg::sq_sel(cmd.step);
        mag_sel = mag_reg[0];
        unique case (sel.comp)
            2'd1:    mag_sel = mag_reg[1];
            2'd2:    mag_sel = mag_reg[2];
            default: mag_sel = mag_reg[0];
        endcase
        op_a = mag_sel[pva_pkg::MAG_LO_W-1:0];
        op_b = mag_sel[pva_pkg::MAG_LO_W-1:0];
        unique case (sel.part)
            pva_pkg::PART_HH:
            begin
                op_a = pva_pkg::MAG_LO_W'(mag_sel[AW-1:pva_pkg::MAG_LO_W]);
                op_b = pva_pkg::MAG_LO_W'(mag_sel[AW-1:pva_pkg::MAG_LO_W]);
            end
            pva_pkg::PART_HL:
            begin
                op_a = pva_pkg::MAG_LO_W'(mag_sel[AW-1:pva_pkg::MAG_LO_W]);
            end
            default:
            begin
            end
        endcase
        unique case (sq_part_reg)
            pva_pkg::PART_HH: sq_add = QW'(sq_prod_reg) << (2 * pva_pkg::MAG_LO_W);
            pva_pkg::PART_HL: sq_add = QW'(sq_prod_reg) << (pva_pkg::MAG_LO_W + 1);
            default:          sq_add = QW'(sq_prod_reg);
        endcase
    end

    // One square root digit per step.
    assign rem_sh = {rem_reg, sq_acc_reg[QW-1:QW-2]};
    assign trial  = (RW+2)'({root_reg, 2'b01});

    // Polygon state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            sum_en_reg  <= 1'b0;
            prev_en_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                anchor_reg[i] <= '0;
                prev_reg[i]   <= '0;
                sum_reg[i]    <= '0;
            end
        end
        else if (cmd.take)
        begin
            if (counted)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        anchor_reg[i] <= vin[i];
                end
            end
            else
            begin
                flag_reg <= 1'b1;
            end
            sum_en_reg  <= counted && (count_reg >= pva_pkg::COUNT_W'(2));
            prev_en_reg <= counted && (count_reg != '0);
        end
        else if (cmd.acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (sum_en_reg)
                    sum_reg[i] <= sum_reg[i] + AW'((PW+1)'(pa_reg[i]) - (PW+1)'(pb_reg[i]));
                if (prev_en_reg)
                    prev_reg[i] <= side_reg[i];
            end
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                anchor_reg[i] <= '0;
                prev_reg[i]   <= '0;
                sum_reg[i]    <= '0;
            end
        end
    end

    // Side vectors, cross products, magnitudes, squaring, root, result
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            for (int i = 0; i < 3; i++)
                side_reg[i] <= SW'(vin[i]) - SW'(anchor_reg[i]);
        end
        if (cmd.mul)
        begin
            pa_reg[0] <= prev_reg[1] * side_reg[2];
            pb_reg[0] <= prev_reg[2] * side_reg[1];
            pa_reg[1] <= prev_reg[2] * side_reg[0];
            pb_reg[1] <= prev_reg[0] * side_reg[2];
            pa_reg[2] <= prev_reg[0] * side_reg[1];
            pb_reg[2] <= prev_reg[1] * side_reg[0];
        end
        if (cmd.mag)
        begin
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= sum_reg[i][AW-1] ? AW'(-sum_reg[i]) : AW'(sum_reg[i]);
            sq_acc_reg <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        if (cmd.sq)
        begin
            sq_prod_reg <= op_a * op_b;
            sq_part_reg <= sel.part;
            if (cmd.step != '0)
                sq_acc_reg <= sq_acc_reg + sq_add;
        end
        if (cmd.root)
        begin
            sq_acc_reg <= sq_acc_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= RW'(rem_sh - trial);
                root_reg <= {root_reg[pva_pkg::AREA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= RW'(rem_sh);
                root_reg <= {root_reg[pva_pkg::AREA_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            area_reg  <= root_reg;
            total_reg <= count_reg;
            ovf_reg   <= flag_reg;
        end
    end

    assign double_area  = area_reg;
    assign vertex_total = total_reg;
    assign overflowed   = ovf_reg;

endmodule

// File: sv/polygon_vector_area_3d.sv
// Channel  Direction  Payload                                         Marker
// s_*      in         tdata: coord_x[15:0] coord_y[31:16] coord_z[47:32] tlast: last_vertex
// m_*      out        tdata: double_area[47:0] vertex_total[60:48]    none
//                            overflowed[61], zero pad [63:62]
//
// A vertex passes through accept, cross-product multiply and accumulate.
// A final vertex then goes on, before the next item is accepted, to a magnitude step,
// the squaring steps on the shared 24x24 squaring multiplier, the digit-by-digit
// square root (one result bit per cycle) and an emit step.
// rst_n clears the controller, the vertex count, the overflow flag and the sums.
// A result waits in the output register; only a second result stalls, in EMIT.
module polygon_vector_area_3d
#(
    parameter int MAX_VERTICES = pva_pkg::MAX_VERTICES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pva_pkg::IN_DATA_W-1:0]       s_tdata,  // coord_x, coord_y, coord_z
    input  logic                                s_tlast,  // last_vertex
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pva_pkg::OUT_DATA_W-1:0]      m_tdata   // double_area, vertex_total,
                                                          // overflowed, zero pad
);

    pva_pkg::pva_cmd_t                  cmd;
    logic [pva_pkg::AREA_W-1:0]         double_area;
    logic [pva_pkg::COUNT_W-1:0]        vertex_total;
    logic                               overflowed;
    logic signed [pva_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;

    // Unpack the vertex: x lowest.
    assign coord_x = s_tdata[pva_pkg::COORD_W-1:0];
    assign coord_y = s_tdata[2*pva_pkg::COORD_W-1:pva_pkg::COORD_W];
    assign coord_z = s_tdata[3*pva_pkg::COORD_W-1:2*pva_pkg::COORD_W];

    // Sequence accept, multiply, accumulate and the final magnitude steps.
    pva_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Hold anchor, sides, sums and the square root unit.
    pva_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .double_area  (double_area),
        .vertex_total (vertex_total),
        .overflowed   (overflowed)
    );

    // Pack the result: area lowest, pad the top to whole bytes.
    assign m_tdata = {2'b00, overflowed, vertex_total, double_area};

`ifndef SYNTHESIS
    // Drop no vertex: no input is taken while a vertex is still in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.mul || cmd.acc || cmd.mag || cmd.sq || cmd.root))
    else $error("input ready while a vertex is in work");

    // Never overwrite a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

    // A new result appears only after an emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.emit))
    else $error("result shown without an emit step");

    // Each multiply is followed by its accumulate.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> cmd.acc)
    else $error("multiply not followed by accumulate");
`endif

endmodule
